[src/coo_to_csr_builder_macros.svh]
// ---------------------------------------------------------------------------
// coo_to_csr_builder assertion macros
// Shared concurrent assertion forms for the COO to CSR builder.
// ---------------------------------------------------------------------------
`ifndef COO_TO_CSR_BUILDER_MACROS_SVH
`define COO_TO_CSR_BUILDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTC_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("coo_to_csr_builder assertion failed");

// Next-cycle implication, disabled during reset.
`define CTC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("coo_to_csr_builder assertion failed");

`endif

[src/ctc_pkg.sv]
// ---------------------------------------------------------------------------
// ctc_pkg
// Types and fixed field widths of the COO to CSR builder.
// ---------------------------------------------------------------------------
package ctc_pkg;

    localparam int VAL_W   = 64;
    localparam int GIDX_W  = 20;
    localparam int ROW_W   = 6;
    localparam int CCNT_W  = 21;
    localparam int IDX_W   = 13;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 21;

    typedef enum logic [KIND_W-1:0] {
        KIND_PTR    = 2'd0,
        KIND_ENTRY  = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ctc_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } ctc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic out_full;
    } ctc_status_t;

endpackage

[src/ctc_in_if.sv]
// ---------------------------------------------------------------------------
// ctc_in_if
// Input channel of the COO to CSR builder: insert or finish transactions.
// ---------------------------------------------------------------------------
interface ctc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [ctc_pkg::VAL_W-1:0]  value_bits;
    logic [ctc_pkg::GIDX_W-1:0] global_row;
    logic [ctc_pkg::GIDX_W-1:0] global_col;

    modport source (output valid, output func, output value_bits,
                    output global_row, output global_col, input ready);
    modport sink   (input valid, input func, input value_bits,
                    input global_row, input global_col, output ready);
endinterface

[src/ctc_out_if.sv]
// ---------------------------------------------------------------------------
// ctc_out_if
// Result channel of the COO to CSR builder: pointers, entries, rejects.
// ---------------------------------------------------------------------------
interface ctc_out_if;
    logic                       valid;
    logic                       ready;
    logic [ctc_pkg::KIND_W-1:0] kind;
    logic [ctc_pkg::IDX_W-1:0]  index;
    logic [ctc_pkg::GIDX_W-1:0] local_col;
    logic [ctc_pkg::VAL_W-1:0]  entry_value;
    logic [ctc_pkg::IDX_W-1:0]  row_pointer;
    logic                       last;

    modport source (output valid, output kind, output index, output local_col,
                    output entry_value, output row_pointer, output last,
                    input ready);
    modport sink   (input valid, input kind, input index, input local_col,
                    input entry_value, input row_pointer, input last,
                    output ready);
endinterface

[src/ctc_ctrl.sv]
// ---------------------------------------------------------------------------
// ctc_ctrl
// Controller: accepts transactions and paces the datapath one result a step.
// ---------------------------------------------------------------------------
module ctc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  ctc_pkg::ctc_status_t status,
    output ctc_pkg::ctc_cmd_t    cmd
);

    ctc_pkg::ctc_state_t state_reg;
    ctc_pkg::ctc_state_t state_next;
    logic                load_ok;

    // output register free, or being drained this cycle
    assign load_ok = !status.out_full || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ctc_pkg::ST_RUN;
                end
            end
            ctc_pkg::ST_RUN:
            begin
                if (load_ok && status.done && !in_valid)
                begin
                    state_next = ctc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ctc_pkg::ST_RUN:
            begin
                cmd.step = load_ok;
                // take the next transaction as the last result goes out
                in_ready = load_ok && status.done;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.accept = in_valid && in_ready;
    end

endmodule

[src/ctc_datapath.sv]
// ---------------------------------------------------------------------------
// ctc_datapath
// Datapath: configuration, row and entry counters, result register.
// ---------------------------------------------------------------------------
module ctc_datapath #(
    parameter int MAX_ROWS    = 63,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                func,
    input  logic [ctc_pkg::VAL_W-1:0]           value_bits,
    input  logic [ctc_pkg::GIDX_W-1:0]          global_row,
    input  logic [ctc_pkg::GIDX_W-1:0]          global_col,
    input  logic                                out_ready,
    input  ctc_pkg::ctc_cmd_t                   cmd,
    output ctc_pkg::ctc_status_t                status,
    output logic                                out_valid,
    output logic [ctc_pkg::KIND_W-1:0]          kind,
    output logic [ctc_pkg::IDX_W-1:0]           index,
    output logic [ctc_pkg::GIDX_W-1:0]          local_col,
    output logic [ctc_pkg::VAL_W-1:0]           entry_value,
    output logic [ctc_pkg::IDX_W-1:0]           row_pointer,
    output logic                                last
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W = ctc_pkg::ROW_W;
    localparam int GW    = ctc_pkg::GIDX_W;
    localparam int IW    = ctc_pkg::IDX_W;

    // configuration
    logic [GW-1:0]               first_row_reg;
    logic [GW-1:0]               first_col_reg;
    logic [ROW_W-1:0]            row_count_reg;
    logic [ctc_pkg::CCNT_W-1:0]  col_count_reg;

    // latched transaction
    logic                        func_reg;
    logic [ctc_pkg::VAL_W-1:0]   value_reg;
    logic [GW-1:0]               grow_reg;
    logic [GW-1:0]               gcol_reg;

    // matrix state
    logic [ROW_W-1:0]            cur_row_reg;
    logic [CNT_W-1:0]            cnt_reg;

    // result register
    logic                        out_valid_reg;
    logic [ctc_pkg::KIND_W-1:0]  kind_reg;
    logic [IW-1:0]               index_reg;
    logic [GW-1:0]               lcol_reg;
    logic [ctc_pkg::VAL_W-1:0]   value_out_reg;
    logic [IW-1:0]               ptr_reg;
    logic                        last_reg;

    logic [ROW_W-1:0]            rows_eff;
    logic [GW-1:0]               row_off;
    logic [GW-1:0]               col_off;
    logic                        row_ok;
    logic                        col_ok;
    logic                        full;
    logic                        ok;
    logic [ROW_W-1:0]            lrow;
    logic                        past_end;
    logic                        fin_last;
    logic                        skip_row;
    logic                        done;
    logic                        emit;
    logic [IW+CNT_W-1:0]         cnt_ext;
    logic [IW-1:0]               cnt_idx;
    logic [IW+ROW_W-1:0]         row_ext;
    logic [IW-1:0]               row_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_row_reg <= '0;
            first_col_reg <= '0;
            row_count_reg <= ROW_W'(63);
            col_count_reg <= ctc_pkg::CCNT_W'(1048576);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctc_pkg::REG_FIRST_ROW: first_row_reg <= cfg_wdata[GW-1:0];
                ctc_pkg::REG_FIRST_COL: first_col_reg <= cfg_wdata[GW-1:0];
                ctc_pkg::REG_ROW_COUNT: row_count_reg <= cfg_wdata[ROW_W-1:0];
                ctc_pkg::REG_COL_COUNT: col_count_reg <= cfg_wdata[ctc_pkg::CCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func;
            value_reg <= value_bits;
            grow_reg  <= global_row;
            gcol_reg  <= global_col;
        end
    end

    // classify the held transaction
    always_comb
    begin
        rows_eff = (row_count_reg > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : row_count_reg;
        row_off  = grow_reg - first_row_reg;
        col_off  = gcol_reg - first_col_reg;
        row_ok   = (grow_reg >= first_row_reg)
                   && (row_off < {{(GW-ROW_W){1'b0}}, rows_eff});
        col_ok   = (gcol_reg >= first_col_reg) && ({1'b0, col_off} < col_count_reg);
        full     = cnt_reg >= CNT_W'(MAX_ENTRIES);
        ok       = row_ok && col_ok && !full;
        lrow     = row_off[ROW_W-1:0];
        past_end = cur_row_reg > rows_eff;
        fin_last = cur_row_reg == rows_eff;
        skip_row = cur_row_reg < lrow;
        cnt_ext  = {{IW{1'b0}}, cnt_reg};
        cnt_idx  = cnt_ext[IW-1:0];
        row_ext  = {{IW{1'b0}}, cur_row_reg};
        row_idx  = row_ext[IW-1:0];
        if (func_reg == ctc_pkg::FUNC_FINISH)
        begin
            done = past_end || fin_last;
            emit = !past_end;
        end
        else
        begin
            done = !ok || !skip_row;
            emit = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cnt_reg     <= '0;
        end
        else if (cmd.step)
        begin
            if (func_reg == ctc_pkg::FUNC_FINISH)
            begin
                if (done)
                begin
                    cur_row_reg <= '0;
                    cnt_reg     <= '0;
                end
                else
                begin
                    cur_row_reg <= cur_row_reg + 1'b1;
                end
            end
            else if (ok)
            begin
                if (skip_row)
                begin
                    cur_row_reg <= cur_row_reg + 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && emit)
        begin
            last_reg <= done;
            if (func_reg == ctc_pkg::FUNC_FINISH || (ok && skip_row))
            begin
                kind_reg      <= ctc_pkg::KIND_PTR;
                index_reg     <= row_idx;
                lcol_reg      <= '0;
                value_out_reg <= '0;
                ptr_reg       <= cnt_idx;
            end
            else if (ok)
            begin
                kind_reg      <= ctc_pkg::KIND_ENTRY;
                index_reg     <= cnt_idx;
                lcol_reg      <= col_off;
                value_out_reg <= value_reg;
                ptr_reg       <= '0;
            end
            else
            begin
                kind_reg      <= ctc_pkg::KIND_REJECT;
                index_reg     <= cnt_idx;
                lcol_reg      <= '0;
                value_out_reg <= '0;
                ptr_reg       <= '0;
            end
        end
    end

    assign status.done     = done;
    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign index           = index_reg;
    assign local_col       = lcol_reg;
    assign entry_value     = value_out_reg;
    assign row_pointer     = ptr_reg;
    assign last            = last_reg;

endmodule

[src/coo_to_csr_builder.sv]
// ---------------------------------------------------------------------------
// coo_to_csr_builder
// Streams row-ordered COO entries out as CSR row pointers and entries.
// ---------------------------------------------------------------------------
// Usage:
//   entries: valid/ready channel; func selects insert (entry with value,
//     global row and column) or finish (close the matrix). A transaction
//     is taken when valid and ready are both high.
//   results: valid/ready channel; each result is a row end pointer, a
//     stored entry or a rejected entry; last marks the final result of the
//     transaction that caused it. A finish past the row count emits nothing.
//   cfg: write enable, register index and data; write only while idle.
// Timing: a transaction is latched into the datapath at acceptance and then
//   emits one result per cycle, while the receiver does not stall, into a
//   single output register. The next item is taken in the cycle its
//   predecessor's last result loads, giving one single-result item per
//   cycle while the receiver does not stall. Skipped rows and finish sweeps
//   emit one pointer per step, paced by the row counter.
// Reset clears the counters and the result valid flag and returns the
// configuration to its defaults.
// A stalled receiver holds the result register and freezes the sweep.
// ---------------------------------------------------------------------------
`include "coo_to_csr_builder_macros.svh"

module coo_to_csr_builder #(
    parameter int MAX_ROWS    = 63,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctc_pkg::CFG_W-1:0]       cfg_wdata,
    ctc_in_if.sink                          entries,
    ctc_out_if.source                       results
);

    ctc_pkg::ctc_cmd_t    cmd;
    ctc_pkg::ctc_status_t status;

    // sequence transactions and pace result steps
    ctc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (entries.valid),
        .in_ready  (entries.ready),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // hold configuration, counters and the result register
    ctc_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .func        (entries.func),
        .value_bits  (entries.value_bits),
        .global_row  (entries.global_row),
        .global_col  (entries.global_col),
        .out_ready   (results.ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (results.valid),
        .kind        (results.kind),
        .index       (results.index),
        .local_col   (results.local_col),
        .entry_value (results.entry_value),
        .row_pointer (results.row_pointer),
        .last        (results.last)
    );

    // a transaction taken mid-item only while the previous item finishes
    `CTC_ASSERT_NOW(a_accept_on_done, clk, rst_n, cmd.accept && cmd.step, status.done)
    // an unfinished step always loads a pointer
    `CTC_ASSERT_NEXT(a_step_loads, clk, rst_n, cmd.step && !status.done, results.valid)
    // a reject is always the only result of its transaction
    `CTC_ASSERT_NOW(a_reject_last, clk, rst_n,
        results.valid && (results.kind == ctc_pkg::KIND_REJECT), results.last)

endmodule
